// ===== hdl/stsum_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment tree range sum: shared definitions
// Tree geometry, field widths and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package stsum_pkg;

   // Tree geometry: node 1 is the root, leaves are nodes LEAVES .. 2*LEAVES-1.
   localparam int LEAVES = 1024;
   localparam int LEAF_W = $clog2(LEAVES);
   localparam int NODE_W = LEAF_W + 1;
   localparam int NODES  = 2 * LEAVES;

   // Item field widths.
   localparam int POS_W = 10;
   localparam int VAL_W = 32;
   localparam int SUM_W = 42;

   // Range walk indexes carry headroom for the step past the last leaf.
   localparam int IDX_W = ((NODE_W > POS_W) ? NODE_W : POS_W) + 2;

   // Stream word widths.
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 48;

   // Operation codes carried in req_tuser.
   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_SUM    = 1'b1;

   // Commands from the controller, at most one active per cycle.
   typedef struct packed {
      logic load;        // capture the accepted word
      logic clear;       // zero one node of the clearing pass
      logic leaf_write;  // write the leaf, read its sibling
      logic up_step;     // write one ancestor sum, read the next sibling
      logic left_step;   // left end of the range walk
      logic right_step;  // right end of the range walk, then go up a level
      logic rsp_load;    // move the finished sum into the output register
   } stsum_cmd_type;

   // Status back to the controller.
   typedef struct packed {
      logic clear_last;  // clearing pass is at its last node
      logic op_sum;      // incoming word is a range sum
      logic pos_ok;      // incoming assign position lies inside the tree
      logic at_top;      // the ancestor being written is the root
      logic l_le_r;      // range walk still has nodes between its ends
      logic rsp_busy;    // output register holds a word that is not taken
   } stsum_status_type;

endpackage

`default_nettype wire

// ===== hdl/stsum_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module stsum_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/stsum_ctrl.sv =====
// ----------------------------------------------------------------------------
// Segment tree range sum: controller
// Sequences the clearing pass, the bottom-up assign walk and the two-ended
// range walk, and owns the input handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module stsum_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire stsum_pkg::stsum_status_type status,
   output stsum_pkg::stsum_cmd_type         cmd
);

   import stsum_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LEAF,
      S_UP,
      S_LEFT,
      S_RIGHT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign accept     = req_tvalid & ready_ff;
   assign req_tready = ready_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      ready_in = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         S_IDLE: begin
            ready_in = 1'b1;
            if (accept) begin
               cmd.load = 1'b1;
               if (status.op_sum) begin
                  state_in = S_LEFT;
                  ready_in = 1'b0;
               end else if (status.pos_ok) begin
                  state_in = S_LEAF;
                  ready_in = 1'b0;
               end
            end
         end
         S_LEAF: begin
            cmd.leaf_write = 1'b1;
            state_in       = S_UP;
         end
         S_UP: begin
            cmd.up_step = 1'b1;
            if (status.at_top) begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         S_LEFT: begin
            if (status.l_le_r) begin
               cmd.left_step = 1'b1;
               state_in      = S_RIGHT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RIGHT: begin
            cmd.right_step = 1'b1;
            state_in       = S_LEFT;
         end
         S_DONE: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
               ready_in     = 1'b1;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // State and registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   // At most one datapath command is issued per cycle.
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("stsum_ctrl: more than one command at once");

   // An accepted assign inside the tree starts with the leaf write.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !status.op_sum && status.pos_ok) |=> (state_ff == S_LEAF))
      else $error("stsum_ctrl: assign did not start its leaf write");

   // A word is taken only while nothing else is in flight.
   assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (state_ff == S_IDLE))
      else $error("stsum_ctrl: ready outside the idle state");

endmodule

`default_nettype wire

// ===== hdl/stsum_dpath.sv =====
// ----------------------------------------------------------------------------
// Segment tree range sum: datapath
// Node memory, walk indexes, running sums and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stsum_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire stsum_pkg::stsum_cmd_type            cmd,
   output stsum_pkg::stsum_status_type              status,
   input  wire logic                                req_operation,
   input  wire logic        [stsum_pkg::POS_W-1:0]  req_position,
   input  wire logic        [stsum_pkg::VAL_W-1:0]  req_new_value,
   input  wire logic        [stsum_pkg::POS_W-1:0]  req_range_low,
   input  wire logic        [stsum_pkg::POS_W-1:0]  req_range_high,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tvalid,
   output logic             [stsum_pkg::SUM_W-1:0]  rsp_range_sum
);

   import stsum_pkg::*;

   logic [NODE_W-1:0] node_ff, node_in;
   logic [SUM_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  l_ff, l_in;
   logic [IDX_W-1:0]  r_ff, r_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;

   logic [NODE_W-1:0] leaf_node;
   logic [NODE_W-1:0] parent;
   logic [SUM_W-1:0]  up_sum;
   logic [IDX_W-1:0]  hi_sat;
   logic [IDX_W-1:0]  r_dec;

   logic              ram_we;
   logic [NODE_W-1:0] ram_waddr;
   logic [SUM_W-1:0]  ram_wdata;
   logic [NODE_W-1:0] ram_raddr;
   logic [SUM_W-1:0]  ram_rdata;

   // Node memory.
   stsum_ram #(
      .WIDTH (SUM_W),
      .DEPTH (NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Decode of the incoming word.
   assign leaf_node = NODE_W'(LEAVES) + NODE_W'(req_position);
   assign hi_sat    = (IDX_W'(req_range_high) >= IDX_W'(LEAVES)) ?
                      IDX_W'(LEAVES - 1) : IDX_W'(req_range_high);

   // Ancestor update and right end step.
   assign parent = node_ff >> 1;
   assign up_sum = cur_ff + ram_rdata;
   assign r_dec  = r_ff[0] ? r_ff : (r_ff - IDX_W'(1));

   // Status to the controller.
   always_comb begin
      status.clear_last = (node_ff == {NODE_W{1'b1}});
      status.op_sum     = (req_operation == OP_SUM);
      status.pos_ok     = (IDX_W'(req_position) < IDX_W'(LEAVES));
      status.at_top     = (parent == NODE_W'(1));
      status.l_le_r     = (l_ff <= r_ff);
      status.rsp_busy   = rsp_valid_ff & ~rsp_tready;
   end

   // Memory port selection.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = node_ff;
      ram_wdata = '0;
      ram_raddr = node_ff;
      if (cmd.clear) begin
         ram_we = 1'b1;
      end else if (cmd.leaf_write) begin
         ram_we    = 1'b1;
         ram_wdata = cur_ff;
         ram_raddr = node_ff ^ NODE_W'(1);
      end else if (cmd.up_step) begin
         ram_we    = 1'b1;
         ram_waddr = parent;
         ram_wdata = up_sum;
         ram_raddr = parent ^ NODE_W'(1);
      end else if (cmd.left_step) begin
         ram_raddr = l_ff[NODE_W-1:0];
      end else if (cmd.right_step) begin
         ram_raddr = r_ff[NODE_W-1:0];
      end
   end

   // Walk registers and accumulator.
   always_comb begin
      node_in    = node_ff;
      cur_in     = cur_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      acc_in     = rd_pend_ff ? (acc_ff + ram_rdata) : acc_ff;
      rd_pend_in = (cmd.left_step & l_ff[0]) | (cmd.right_step & ~r_ff[0]);
      if (cmd.load) begin
         node_in = leaf_node;
         cur_in  = {{(SUM_W - VAL_W){req_new_value[VAL_W-1]}}, req_new_value};
         l_in    = IDX_W'(LEAVES) + IDX_W'(req_range_low);
         r_in    = IDX_W'(LEAVES) + hi_sat;
         acc_in  = '0;
      end
      if (cmd.clear) begin
         node_in = node_ff + NODE_W'(1);
      end
      if (cmd.up_step) begin
         node_in = parent;
         cur_in  = up_sum;
      end
      if (cmd.left_step && l_ff[0]) begin
         l_in = l_ff + IDX_W'(1);
      end
      if (cmd.right_step) begin
         l_in = l_ff >> 1;
         r_in = r_dec >> 1;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         node_ff      <= node_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff     <= cur_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   // The left end only steps while the range still holds nodes.
   assert property (@(posedge clock) disable iff (reset)
      cmd.left_step |-> (l_ff <= r_ff))
      else $error("stsum_dpath: left step past the right end");

   // A finished sum never overwrites a word still waiting at the output.
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("stsum_dpath: output word overwritten");

   // Ancestor writes never reach the unused node zero.
   assert property (@(posedge clock) disable iff (reset)
      cmd.up_step |-> (parent != '0))
      else $error("stsum_dpath: ancestor write to node zero");

endmodule

`default_nettype wire

// ===== hdl/segment_tree_range_sum_unit.sv =====
// ----------------------------------------------------------------------------
// Segment tree range sum unit
// Point-update, range-sum segment tree over a power-of-two count of leaves.
// ----------------------------------------------------------------------------
// After reset the unit clears its node memory, one node per cycle, and holds
// req_tready low during that pass. It works on one word at a time. An assign
// writes a leaf and then one ancestor per cycle up to the root, gives no
// output word and accepts the next word once the root is written. A range
// sum reads up to two nodes per tree level through the single read port of
// the node memory before its word is loaded into the output register, and
// the next word can be accepted in the cycle after that, even while that
// result still waits to be taken. A range sum that finds the output register
// still occupied waits until the held word is taken. An empty range yields
// zero.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_tree_range_sum_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // req_tdata: position[9:0], new_value[41:10], range_low[51:42],
   // range_high[61:52], zero fill[63:62]
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [stsum_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: operation[0] (0 = assign, 1 = range sum)
   input  wire logic                                 req_tuser,
   // rsp_tdata: range_sum[41:0], zero fill[47:42]
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic      [stsum_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   import stsum_pkg::*;

   stsum_cmd_type    cmd;
   stsum_status_type status;
   logic [SUM_W-1:0] range_sum;

   // Controller.
   stsum_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath with the node memory.
   stsum_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_tuser),
      .req_position   (req_tdata[POS_W-1:0]),
      .req_new_value  (req_tdata[POS_W+VAL_W-1:POS_W]),
      .req_range_low  (req_tdata[2*POS_W+VAL_W-1:POS_W+VAL_W]),
      .req_range_high (req_tdata[3*POS_W+VAL_W-1:2*POS_W+VAL_W]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_range_sum  (range_sum)
   );

   // Result word packing.
   assign rsp_tdata = {{(RSP_TDATA_W - SUM_W){1'b0}}, range_sum};

endmodule

`default_nettype wire
